// ----- src/work_stealing_deque_defines.svh -----
// ----------------------------------------------------------------------------
// Work-stealing deque: assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_DEQUE_DEFINES_SVH
`define WORK_STEALING_DEQUE_DEFINES_SVH

// Checked only outside reset.
`define WSD_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checked at every edge, reset included.
`define WSD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

// ----- src/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants for the work-stealing deque.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int HANDLE_W     = 32;
  localparam int CNT_W        = 7;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_STEAL = 2'd2,
    REQ_PEEK  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    req_t                req_type;
    logic [HANDLE_W-1:0] push_handle;
  } in_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] task_handle;
    status_t             status;
    logic [CNT_W-1:0]    entry_count;
  } out_t;

endpackage

// ----- src/work_stealing_deque.sv -----
// ----------------------------------------------------------------------------
// work_stealing_deque
// Ring of CAPACITY slots holding at most CAPACITY-2 task handles, with a top
// index (push/pop) and a bottom index (steal).
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry requests (push, pop, steal, peek).
//   out_valid/out_ready/out_data return one word per request: the handle
//   taken or peeked, a status and the entry count after the request.
//   A request passes from the input register to the result register,
//   which drives out_valid. One request per cycle is sustained while
//   out_ready stays high. Both slot reads are issued as a request enters
//   the input register, from the index values left by the request ahead
//   of it, with a bypass from that request's slot write.
//   Throughput is set by the single write port of the slot memory: each
//   request writes at most one slot.
//   Reset (rst_n low, synchronous) empties the deque at once: both indices
//   go to zero and in_ready is held low. The slot memory is not swept; a
//   slot is read only when it lies between bottom and top, and such slots
//   have all been written. A peek of an empty deque reports null.
//   When the receiver stalls, the result is held and the request behind it
//   waits in the input register; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
`include "work_stealing_deque_defines.svh"

module work_stealing_deque #(
  parameter int CAPACITY = wsd_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  wsd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output wsd_pkg::out_t  out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = AW + 1;
  localparam int HW = wsd_pkg::HANDLE_W;

  // input register
  logic                iv_r;
  wsd_pkg::req_t       ireq_r;
  logic [HW-1:0]       ih_r;
  // slot read data with write bypass
  logic [HW-1:0]       rt_r, rb_r, bd_r;
  logic                bt_r, bb_r;
  // indices
  logic [IW-1:0]       top_r, bot_r, top_nxt, bot_nxt;
  // result register
  logic                ov_r;
  wsd_pkg::out_t       od_r;

  logic [HW-1:0]       mem [CAPACITY];

  logic                in_fire, proc_fire;
  logic [IW-1:0]       n, t_new, b_new;
  logic                we_c, we;
  logic [AW-1:0]       wa, ra_top, ra_bot;
  logic [HW-1:0]       wd, slot_top, slot_bot;
  wsd_pkg::out_t       res;
  logic                ovf_seen, pop_ok, steal_ok, rst_clean;

  function automatic logic [IW-1:0] held(input logic [IW-1:0] t, input logic [IW-1:0] b);
    logic [IW-1:0] d;
    d = t - b;
    return (d > IW'(CAPACITY)) ? '0 : d;
  endfunction

  assign proc_fire = iv_r && (!ov_r || out_ready);
  assign in_ready  = rst_n && (!iv_r || proc_fire);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign slot_top = bt_r ? bd_r : rt_r;
  assign slot_bot = bb_r ? bd_r : rb_r;
  assign n        = held(top_r, bot_r);

  always_comb begin
    res             = '0;
    res.status      = wsd_pkg::ST_OK;
    t_new           = top_r;
    b_new           = bot_r;
    we_c            = 1'b0;
    wa              = top_r[AW-1:0];
    wd              = ih_r;
    case (ireq_r)
      wsd_pkg::REQ_PUSH: begin
        if (n >= IW'(CAPACITY - 2)) begin
          res.status = wsd_pkg::ST_OVERFLOW;
        end else begin
          we_c  = 1'b1;
          t_new = top_r + IW'(1);
        end
      end
      wsd_pkg::REQ_POP: begin
        if (n == '0 || slot_top == '0) begin
          res.status = wsd_pkg::ST_EMPTY;
        end else begin
          res.task_handle = slot_top;
          we_c  = 1'b1;
          wa    = top_r[AW-1:0] - AW'(1);
          wd    = '0;
          t_new = top_r - IW'(1);
        end
      end
      wsd_pkg::REQ_STEAL: begin
        if (n == '0 || slot_bot == '0) begin
          res.status = wsd_pkg::ST_EMPTY;
        end else begin
          res.task_handle = slot_bot;
          we_c  = 1'b1;
          wa    = bot_r[AW-1:0];
          wd    = '0;
          b_new = bot_r + IW'(1);
        end
      end
      wsd_pkg::REQ_PEEK: begin
        // empty deque: report null without using the slot below top
        res.task_handle = (n == '0) ? '0 : slot_top;
        res.status      = (res.task_handle == '0) ? wsd_pkg::ST_EMPTY : wsd_pkg::ST_OK;
      end
      default: begin
        res.status = wsd_pkg::ST_EMPTY;
      end
    endcase
    res.entry_count = wsd_pkg::CNT_W'(held(t_new, b_new));
  end

  assign we      = proc_fire && we_c;
  assign top_nxt = proc_fire ? t_new : top_r;
  assign bot_nxt = proc_fire ? b_new : bot_r;
  assign ra_top  = top_nxt[AW-1:0] - AW'(1);
  assign ra_bot  = bot_nxt[AW-1:0];

  // slot memory, two registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (in_fire) begin
      rt_r <= mem[ra_top];
      rb_r <= mem[ra_bot];
    end
  end

  // bypass of the write landing on the same edge as the read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      bt_r <= we && (wa == ra_top);
      bb_r <= we && (wa == ra_bot);
      bd_r <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r  <= 1'b0;
      ov_r  <= 1'b0;
      top_r <= '0;
      bot_r <= '0;
    end else begin
      top_r <= top_nxt;
      bot_r <= bot_nxt;
      if (in_ready) begin
        iv_r <= in_valid;
      end
      if (proc_fire) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ireq_r <= in_data.req_type;
      ih_r   <= in_data.push_handle;
    end
    if (proc_fire) begin
      od_r <= res;
    end
  end

  assign ovf_seen  = proc_fire && res.status == wsd_pkg::ST_OVERFLOW;
  assign pop_ok    = proc_fire && ireq_r == wsd_pkg::REQ_POP && res.status == wsd_pkg::ST_OK;
  assign steal_ok  = proc_fire && ireq_r == wsd_pkg::REQ_STEAL && res.status == wsd_pkg::ST_OK;
  assign rst_clean = !ov_r && !iv_r && top_r == bot_r;

  `WSD_ASSERT(a_count_bound, n <= IW'(CAPACITY - 2), "entry count beyond capacity limit")
  `WSD_ASSERT(a_ovf_hold, ovf_seen |=> $stable(top_r), "refused push moved top")
  `WSD_ASSERT(a_pop_step, pop_ok |=> top_r == $past(top_r) - IW'(1), "pop did not step top down")
  `WSD_ASSERT(a_steal_step, steal_ok |=> bot_r == $past(bot_r) + IW'(1), "steal did not move bottom")
  `WSD_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> rst_clean, "reset left state behind")

endmodule
